// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion helper macros
// shared clocked assertion forms for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/rgbac_pkg.sv -----
// ---------------------------------------------------------------------------
// rgba compositing store package
// word types, codes and 1/255 fixed point helpers
// ---------------------------------------------------------------------------
package rgbac_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int CFG_W          = 9;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  // operation codes
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_BLEND = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // property kinds
  localparam logic [1:0] KIND_COLOR = 2'd0;
  localparam logic [1:0] KIND_ALPHA = 2'd1;

  // status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_NO_BG   = 2'd2;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]         operation;
    logic               is_background;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic               first_of_point;
    logic [1:0]         property_kind;
    logic signed [15:0] value_first;
    logic signed [15:0] value_second;
    logic signed [15:0] value_third;
  } rgbac_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] alpha_out;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } rgbac_out_t;

  // floor(v/255), exact for v up to 255*255
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd1 + {9'd0, v[15:8]};
    return s[15:8];
  endfunction

  function automatic logic [15:0] mul8(input logic [7:0] a, input logic [7:0] b);
    return {8'd0, a} * {8'd0, b};
  endfunction

  function automatic logic [7:0] sat255(input logic [8:0] v);
    return v[8] ? 8'hFF : v[7:0];
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [15:0] v);
    logic [7:0] r;
    if (v[15]) begin
      r = 8'd0;
    end else if (|v[14:8]) begin
      r = 8'hFF;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// ----- src/rgba_alpha_compositing_store_top.sv -----
// ---------------------------------------------------------------------------
// rgba compositing pixel store
// rgba store with background colour, read-modify-write compositing
// ---------------------------------------------------------------------------
// One word is taken at a clock edge where start is high and busy low. Its
// result shows on out_word for the single cycle in which out_valid is high,
// and it cannot be held off.
// Steps after the word is taken:
//   set: decode with store read, first multiply, second
//        multiply with write back.
//   read: decode with store read, then the read-out.
//   point outside the image, or no background present: decode only.
// The strobe follows in the next cycle, and busy has already dropped by then.
// A background blend decodes and then, for every pixel in use, reads,
// multiplies, and multiplies with write back. When there is nothing to
// blend it stops after the decode.
// A clear decodes and then sweeps every store entry, MAX_WIDTH*MAX_HEIGHT
// entries (65536 at the defaults). The same clearing pass runs after reset
// with busy high and gives no strobe.
`include "assert_macros.svh"

module rgba_alpha_compositing_store_top
  import rgbac_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rgbac_in_t        in_word,
  output logic             out_valid,
  output rgbac_out_t       out_word,
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WDW   = $clog2(MAX_WIDTH + 1);
  localparam int HDW   = $clog2(MAX_HEIGHT + 1);
  localparam int PW    = XW + HDW;
  localparam int NW    = WDW + HDW;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ADDR = 8'b0000_0010,
    S_M1   = 8'b0000_0100,
    S_M2   = 8'b0000_1000,
    S_BRD  = 8'b0001_0000,
    S_BM1  = 8'b0010_0000,
    S_BM2  = 8'b0100_0000,
    S_CLR  = 8'b1000_0000
  } state_t;

  // control state
  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] width_r, height_r;
  logic [31:0]      bg_r, bg_nxt;
  logic             bgp_r, bgp_nxt;
  logic [7:0]       ra_r, ra_nxt;
  logic [7:0]       abp_r, abp_nxt;
  logic             unset_r, unset_nxt;
  logic [AW:0]      ctr_r, ctr_nxt;
  logic             report_r, report_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  rgbac_in_t        inp_r, inp_nxt;
  rgbac_out_t       out_r, out_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [7:0]       am_r, am_nxt;
  logic [7:0]       p_r [3];
  logic [7:0]       p_nxt [3];
  logic [7:0]       q_r [3];
  logic [7:0]       q_nxt [3];

  // store
  logic [31:0]      store_mem [DEPTH];
  logic [31:0]      mem_rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [31:0]      mem_wdata;

  // decode helpers
  logic [WDW-1:0]   w_eff;
  logic [HDW-1:0]   h_eff;
  logic             inside_img;
  logic [PW-1:0]    addr_sum;
  logic [AW-1:0]    addr_calc;
  logic [NW-1:0]    n_calc;
  logic [31:0]      word_m;
  logic [7:0]       ra_e, abp_e, pa, ba;
  logic             unset_e;
  logic [7:0]       cval [3];
  logic [31:0]      w_new;

  // effective image size and point address
  assign w_eff = (32'(width_r) > 32'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : WDW'(width_r);
  assign h_eff = (32'(height_r) > 32'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : HDW'(height_r);
  assign inside_img = !inp_r.pos_x[15] && !inp_r.pos_y[15] &&
                      (32'(inp_r.pos_x[14:0]) < 32'(w_eff)) &&
                      (32'(inp_r.pos_y[14:0]) < 32'(h_eff));
  assign addr_sum  = PW'(inp_r.pos_x[XW-1:0]) * PW'(h_eff) + PW'(inp_r.pos_y[YW-1:0]);
  assign addr_calc = addr_sum[AW-1:0];
  assign n_calc    = NW'(w_eff) * NW'(h_eff);
  assign mem_raddr = (state_r == S_BRD) ? ctr_r[AW-1:0] : addr_calc;

  assign cval[0] = clamp8(inp_r.value_first);
  assign cval[1] = clamp8(inp_r.value_second);
  assign cval[2] = clamp8(inp_r.value_third);

  assign word_m  = inp_r.is_background ? bg_r : mem_rdata_r;
  assign ra_e    = inp_r.first_of_point ? 8'hFF : ra_r;
  assign abp_e   = inp_r.first_of_point ? word_m[31:24] : abp_r;
  assign unset_e = inp_r.first_of_point | unset_r;
  assign pa      = (state_r == S_BM1) ? mem_rdata_r[31:24] : word_r[31:24];
  assign ba      = bg_r[31:24];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    bg_nxt        = bg_r;
    bgp_nxt       = bgp_r;
    ra_nxt        = ra_r;
    abp_nxt       = abp_r;
    unset_nxt     = unset_r;
    ctr_nxt       = ctr_r;
    report_nxt    = report_r;
    out_valid_nxt = 1'b0;
    inp_nxt       = inp_r;
    out_nxt       = out_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    word_nxt      = word_r;
    am_nxt        = am_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = word_r;
    w_new         = word_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          inp_nxt   = in_word;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        out_nxt = '0;
        case (inp_r.operation)
          OP_SET, OP_READ: begin
            if (!inp_r.is_background && !inside_img) begin
              out_nxt.status = ST_OUTSIDE;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else if (inp_r.is_background && inp_r.operation == OP_READ && !bgp_r) begin
              out_nxt.status = ST_NO_BG;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              idx_nxt   = addr_calc;
              state_nxt = S_M1;
            end
          end
          OP_BLEND: begin
            if (!bgp_r) begin
              out_nxt.status = ST_NO_BG;
              out_valid_nxt  = 1'b1;
              state_nxt      = S_IDLE;
            end else if (ba == 8'd0 || n_calc == '0) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end else begin
              ctr_nxt   = '0;
              n_nxt     = n_calc;
              state_nxt = S_BRD;
            end
          end
          default: begin
            ctr_nxt    = '0;
            report_nxt = 1'b1;
            bg_nxt     = '0;
            bgp_nxt    = 1'b0;
            state_nxt  = S_CLR;
          end
        endcase
      end
      S_M1: begin
        if (inp_r.operation == OP_READ) begin
          out_nxt.status    = ST_DONE;
          out_nxt.alpha_out = word_m[31:24];
          out_nxt.red_out   = word_m[23:16];
          out_nxt.green_out = word_m[15:8];
          out_nxt.blue_out  = word_m[7:0];
          out_valid_nxt     = 1'b1;
          state_nxt         = S_IDLE;
        end else begin
          // first multiply of the composite
          word_nxt  = word_m;
          abp_nxt   = abp_e;
          ra_nxt    = ra_e;
          unset_nxt = unset_e;
          am_nxt    = unset_e ? 8'hFF : word_m[31:24];
          if (inp_r.is_background) begin
            bgp_nxt = 1'b1;
          end
          for (int k = 0; k < 3; k++) begin
            p_nxt[k] = div255(mul8(cval[k], ra_e));
            q_nxt[k] = div255(mul8(word_m[23-8*k -: 8], am_nxt));
          end
          if (inp_r.property_kind == KIND_COLOR) begin
            unset_nxt = 1'b0;
          end else if (inp_r.property_kind == KIND_ALPHA) begin
            ra_nxt    = div255(mul8(ra_e, 8'hFF - cval[0]));
            unset_nxt = 1'b0;
          end
          state_nxt = S_M2;
        end
      end
      S_M2: begin
        // second multiply and write back
        if (inp_r.property_kind == KIND_COLOR) begin
          w_new[31:24] = am_r;
          for (int k = 0; k < 3; k++) begin
            w_new[23-8*k -: 8] = sat255({1'b0, p_r[k]} +
                                        {1'b0, div255(mul8(q_r[k], 8'hFF - ra_r))});
          end
        end else if (inp_r.property_kind == KIND_ALPHA) begin
          w_new[31:24] = sat255({1'b0, ra_r} + {1'b0, div255(mul8(abp_r, 8'hFF - ra_r))});
        end
        if (inp_r.is_background) begin
          bg_nxt = w_new;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = idx_r;
          mem_wdata = w_new;
        end
        out_nxt       = '0;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_BRD: begin
        state_nxt = S_BM1;
      end
      S_BM1: begin
        word_nxt = mem_rdata_r;
        am_nxt   = sat255({1'b0, pa} + {1'b0, div255(mul8(ba, 8'hFF - pa))});
        for (int k = 0; k < 3; k++) begin
          p_nxt[k] = div255(mul8(bg_r[23-8*k -: 8], ba));
        end
        state_nxt = S_BM2;
      end
      S_BM2: begin
        w_new[31:24] = am_r;
        for (int k = 0; k < 3; k++) begin
          w_new[23-8*k -: 8] = sat255({1'b0, word_r[23-8*k -: 8]} +
                                      {1'b0, div255(mul8(p_r[k], 8'hFF - pa))});
        end
        mem_waddr = ctr_r[AW-1:0];
        mem_wdata = w_new;
        mem_we    = (pa != 8'hFF);
        if (32'(ctr_r) + 32'd1 == 32'(n_r)) begin
          out_nxt       = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ctr_nxt   = ctr_r + (AW+1)'(1);
          state_nxt = S_BRD;
        end
      end
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = ctr_r[AW-1:0];
        mem_wdata = '0;
        if (32'(ctr_r) == DEPTH - 1) begin
          out_nxt       = '0;
          out_valid_nxt = report_r;
          state_nxt     = S_IDLE;
        end else begin
          ctr_nxt = ctr_r + (AW+1)'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      width_r     <= CFG_RESET;
      height_r    <= CFG_RESET;
      bg_r        <= '0;
      bgp_r       <= 1'b0;
      ra_r        <= 8'hFF;
      abp_r       <= 8'd0;
      unset_r     <= 1'b1;
      ctr_r       <= '0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bg_r        <= bg_nxt;
      bgp_r       <= bgp_nxt;
      ra_r        <= ra_nxt;
      abp_r       <= abp_nxt;
      unset_r     <= unset_nxt;
      ctr_r       <= ctr_nxt;
      report_r    <= report_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_addr == REG_WIDTH) begin
        width_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == REG_HEIGHT) begin
        height_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    inp_r  <= inp_nxt;
    out_r  <= out_nxt;
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    word_r <= word_nxt;
    am_r   <= am_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
  end

  // pixel store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= store_mem[mem_raddr];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  `ASSERT_CLK(a_strobe_single, out_valid_r |=> !out_valid_r, "result strobe held two cycles")
  `ASSERT_CLK(a_strobe_idle, out_valid_r |-> state_r == S_IDLE, "result shown while busy")
  `ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "accepted word did not start work")
  `ASSERT_ALWAYS(a_clear_zero, (state_r == S_CLR && mem_we) |-> mem_wdata == 32'd0,
                 "clearing pass wrote non-zero data")

endmodule

// ----- verif/rgba_alpha_compositing_store_top_tb.sv -----
// ---------------------------------------------------------------------------
// rgba compositing pixel store testbench
// drives set, read, blend and clear words through the command port under
// several image sizes and idle patterns, predicts every result word from
// a behavioural copy of the store and checks each field as it arrives
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgba_alpha_compositing_store_top_tb;
  import rgbac_pkg::*;

  // behavioural copy of the store and queue of expected result words
  class composite_scoreboard;
    bit [31:0]   pixels [65536];
    bit [31:0]   bg_word;
    bit          bg_present;
    int unsigned run_alpha;
    int unsigned alpha_prior;
    bit          alpha_unset;
    int unsigned img_w;
    int unsigned img_h;
    rgbac_out_t  pending [$];
    int          errors;

    function new();
      foreach (pixels[i]) pixels[i] = '0;
      bg_word = '0;
      bg_present = 0;
      run_alpha = 255;
      alpha_prior = 0;
      alpha_unset = 1;
      img_w = 256;
      img_h = 256;
      errors = 0;
    endfunction

    function void write_reg(logic addr, logic [CFG_W-1:0] data);
      if (addr == REG_WIDTH) img_w = data;
      else img_h = data;
    endfunction

    function int unsigned eff_w();
      return img_w > 256 ? 256 : img_w;
    endfunction

    function int unsigned eff_h();
      return img_h > 256 ? 256 : img_h;
    endfunction

    function int unsigned clamp_val(logic signed [15:0] v);
      int s;
      s = v;
      if (s <= 0) return 0;
      if (s >= 255) return 255;
      return s;
    endfunction

    function int unsigned sat(int unsigned v);
      return v > 255 ? 255 : v;
    endfunction

    function bit [31:0] blend_pixel(bit [31:0] p);
      int unsigned ba, pa, bc, c;
      bit [31:0] r;
      ba = bg_word[31:24];
      pa = p[31:24];
      r = p;
      if (pa == 255) return p;
      r[31:24] = sat(pa + (ba * (255 - pa)) / 255);
      for (int k = 0; k < 3; k++) begin
        bc = (bg_word[8*k +: 8] * ba) / 255;
        c = p[8*k +: 8] + (bc * (255 - pa)) / 255;
        r[8*k +: 8] = sat(c);
      end
      return r;
    endfunction

    // work out the result of one accepted word and update the store copy
    function void note_input(rgbac_in_t it);
      rgbac_out_t e;
      int x, y;
      int unsigned w, h, idx, n, ra, am, c, old, v;
      bit [31:0] word;
      e = '0;
      w = eff_w();
      h = eff_h();
      x = it.pos_x;
      y = it.pos_y;
      idx = 0;
      word = '0;
      if (it.operation == OP_SET || it.operation == OP_READ) begin
        if (!it.is_background) begin
          if (x < 0 || y < 0 || x >= w || y >= h) begin
            e.status = ST_OUTSIDE;
            pending = {pending, e};
            return;
          end
          idx = x * h + y;
          word = pixels[idx];
        end else begin
          if (it.operation == OP_READ && !bg_present) begin
            e.status = ST_NO_BG;
            pending = {pending, e};
            return;
          end
          word = bg_word;
        end
      end
      case (it.operation)
        OP_READ: begin
          e.alpha_out = word[31:24];
          e.red_out   = word[23:16];
          e.green_out = word[15:8];
          e.blue_out  = word[7:0];
        end
        OP_SET: begin
          if (it.is_background) bg_present = 1;
          if (it.first_of_point) begin
            run_alpha = 255;
            alpha_prior = word[31:24];
            alpha_unset = 1;
          end
          if (it.property_kind == KIND_COLOR) begin
            ra = run_alpha;
            if (alpha_unset) begin
              word[31:24] = 8'hFF;
              alpha_unset = 0;
            end
            am = word[31:24];
            for (int k = 0; k < 3; k++) begin
              c = clamp_val(k == 0 ? it.value_first :
                            k == 1 ? it.value_second : it.value_third);
              old = word[8*(2-k) +: 8];
              v = (c * ra) / 255 + (((old * am) / 255) * (255 - ra)) / 255;
              word[8*(2-k) +: 8] = sat(v);
            end
          end else if (it.property_kind == KIND_ALPHA) begin
            run_alpha = (run_alpha * (255 - clamp_val(it.value_first))) / 255;
            word[31:24] = sat(run_alpha + (alpha_prior * (255 - run_alpha)) / 255);
            alpha_unset = 0;
          end
          if (it.is_background) bg_word = word;
          else pixels[idx] = word;
        end
        OP_BLEND: begin
          if (!bg_present) begin
            e.status = ST_NO_BG;
          end else if (bg_word[31:24] != 0) begin
            n = w * h;
            for (int unsigned i = 0; i < n; i++) pixels[i] = blend_pixel(pixels[i]);
          end
        end
        default: begin
          foreach (pixels[i]) pixels[i] = '0;
          bg_word = '0;
          bg_present = 0;
        end
      endcase
      pending = {pending, e};
    endfunction

    // compare one result word with the oldest expectation
    function void check_result(rgbac_out_t got);
      rgbac_out_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status expected %0d got %0d", e.status, got.status);
        errors++;
      end
      if (got.alpha_out !== e.alpha_out) begin
        $error("alpha_out expected %0d got %0d", e.alpha_out, got.alpha_out);
        errors++;
      end
      if (got.red_out !== e.red_out) begin
        $error("red_out expected %0d got %0d", e.red_out, got.red_out);
        errors++;
      end
      if (got.green_out !== e.green_out) begin
        $error("green_out expected %0d got %0d", e.green_out, got.green_out);
        errors++;
      end
      if (got.blue_out !== e.blue_out) begin
        $error("blue_out expected %0d got %0d", e.blue_out, got.blue_out);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  rgbac_in_t        in_word = '0;
  logic             out_valid;
  rgbac_out_t       out_word;
  logic             cfg_we = 1'b0;
  logic             cfg_addr = REG_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  composite_scoreboard sb = new();
  int idle_pct;
  int clears_left;
  int cur_x, cur_y;

  rgba_alpha_compositing_store_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_word);
  end

  function automatic rgbac_in_t mk(logic [1:0] op, logic bg, int x, int y, logic first,
                                   logic [1:0] kind, int v1, int v2, int v3);
    rgbac_in_t it;
    it.operation = op;
    it.is_background = bg;
    it.pos_x = 16'(x);
    it.pos_y = 16'(y);
    it.first_of_point = first;
    it.property_kind = kind;
    it.value_first = 16'(v1);
    it.value_second = 16'(v2);
    it.value_third = 16'(v3);
    return it;
  endfunction

  // present one word, wait for it to be taken, then maybe go idle
  task automatic send(rgbac_in_t it);
    in_word <= it;
    start <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    sb.note_input(it);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic addr, int data);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= CFG_W'(data);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(addr, CFG_W'(data));
  endtask

  function automatic int rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 255);
    if (r < 85) return $signed(16'($urandom));
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return -1;
      2: return 0;
      3: return 255;
      4: return 256;
      default: return 32767;
    endcase
  endfunction

  // mostly well-formed point sequences, some noise and out-of-range points
  function automatic rgbac_in_t rand_word();
    int unsigned w, h;
    int r, x, y;
    logic first;
    logic [1:0] op, kind;
    w = sb.eff_w();
    h = sb.eff_h();
    first = ($urandom_range(0, 19) == 0);
    if ($urandom_range(0, 99) < 35) begin
      cur_x = (w > 0) ? $urandom_range(0, w - 1) : $urandom_range(0, 3);
      cur_y = (h > 0) ? $urandom_range(0, h - 1) : $urandom_range(0, 3);
      first = 1'b1;
    end
    x = cur_x;
    y = cur_y;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      x = $signed(16'($urandom));
      y = $signed(16'($urandom));
    end else if (r < 12) begin
      if ($urandom_range(0, 1)) x = $urandom_range(0, 1) ? -1 : w;
      else y = $urandom_range(0, 1) ? -1 : h;
    end
    r = $urandom_range(0, 99);
    if (r < 72) op = OP_SET;
    else if (r < 92 || w * h > 4096) op = OP_READ;
    else op = OP_BLEND;
    if (op == OP_SET && clears_left > 0 && $urandom_range(0, 199) == 0) begin
      op = OP_CLEAR;
      clears_left--;
    end
    r = $urandom_range(0, 99);
    kind = (r < 45) ? KIND_COLOR : (r < 90) ? KIND_ALPHA : 2'($urandom_range(2, 3));
    return mk(op, $urandom_range(0, 99) < 15, x, y, first, kind,
              rand_value(), rand_value(), rand_value());
  endfunction

  initial begin
    static int unsigned ph_w [7] = '{1, 4, 16, 256, 0, 511, 256};
    static int unsigned ph_h [7] = '{1, 7, 9, 2, 5, 3, 256};
    static int          ph_i [7] = '{0, 63, 7, 0, 63, 7, 0};
    idle_pct = 0;
    clears_left = 4;
    cur_x = 0;
    cur_y = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed words at the reset image size
    send(mk(OP_SET, 0, 0, 0, 1, KIND_COLOR, 255, 0, 128));
    send(mk(OP_SET, 0, 0, 0, 0, KIND_ALPHA, 128, 0, 0));
    send(mk(OP_READ, 0, 0, 0, 0, KIND_COLOR, 0, 0, 0));
    send(mk(OP_READ, 1, 0, 0, 0, KIND_COLOR, 0, 0, 0));
    send(mk(OP_BLEND, 0, 0, 0, 0, KIND_COLOR, 0, 0, 0));
    send(mk(OP_SET, 0, 255, 255, 1, KIND_COLOR, -32768, 32767, 300));
    send(mk(OP_SET, 0, 255, 255, 0, KIND_ALPHA, 32767, 0, 0));
    send(mk(OP_SET, 0, -1, 0, 1, KIND_COLOR, 1, 2, 3));
    send(mk(OP_SET, 0, 256, 0, 1, KIND_COLOR, 1, 2, 3));
    send(mk(OP_SET, 0, 3, -32768, 1, KIND_ALPHA, 9, 0, 0));
    send(mk(OP_READ, 0, 0, 32767, 0, KIND_COLOR, 0, 0, 0));
    send(mk(OP_SET, 0, 0, 0, 1, 2'd2, 5, 5, 5));
    send(mk(OP_SET, 0, 0, 0, 0, 2'd3, 5, 5, 5));
    send(mk(OP_SET, 1, 0, 0, 1, KIND_ALPHA, 100, 0, 0));
    send(mk(OP_SET, 1, 0, 0, 0, KIND_COLOR, 40, 200, 255));
    send(mk(OP_READ, 1, 0, 0, 0, KIND_COLOR, 0, 0, 0));
    send(mk(OP_SET, 0, 3, 4, 1, KIND_ALPHA, 200, 0, 0));
    send(mk(OP_SET, 0, 5, 5, 0, KIND_COLOR, 10, 20, 30));
    send(mk(OP_BLEND, 0, 0, 0, 0, KIND_COLOR, 0, 0, 0));
    send(mk(OP_READ, 0, 3, 4, 0, KIND_COLOR, 0, 0, 0));
    send(mk(OP_READ, 0, 5, 5, 0, KIND_COLOR, 0, 0, 0));
    send(mk(OP_CLEAR, 0, 0, 0, 0, KIND_COLOR, 0, 0, 0));
    send(mk(OP_READ, 0, 0, 0, 0, KIND_COLOR, 0, 0, 0));
    send(mk(OP_READ, 1, 0, 0, 0, KIND_COLOR, 0, 0, 0));

    // random phases over image sizes and idle patterns
    for (int p = 0; p < 7; p++) begin
      write_cfg(REG_WIDTH, ph_w[p]);
      write_cfg(REG_HEIGHT, ph_h[p]);
      idle_pct = ph_i[p];
      for (int n = 0; n < 130; n++) begin
        if (n == 60) drain();
        send(rand_word());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS rgba_alpha_compositing_store_top");
    end else begin
      $display("FAIL rgba_alpha_compositing_store_top");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAIL rgba_alpha_compositing_store_top");
    $finish;
  end

endmodule
